FILE: sv/kinematic_motion_rollout_assert.svh
// Assertion macros shared by the rollout block.
// The macros expect signals named clk and arst_n in the scope where they are used.
`ifndef KINEMATIC_MOTION_ROLLOUT_ASSERT_SVH
`define KINEMATIC_MOTION_ROLLOUT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KMR_ASSERT_IMP(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("rollout assertion failed");

// Next-cycle implication, checked out of reset.
`define KMR_ASSERT_NXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("rollout assertion failed");

`endif

FILE: sv/kmr_pkg.sv
// Package for the kinematic motion rollout: payload types, command codes,
// fixed-point constants and helper functions. No dependencies.
`timescale 1ns / 1ps
package kmr_pkg;

	localparam logic signed [31:0] FX_PI      = 32'sd205887;
	localparam logic signed [31:0] FX_TWO_PI  = 32'sd411775;
	localparam logic signed [31:0] FX_HALF_PI = 32'sd102944;
	localparam logic signed [35:0] FX_GAIN    = 36'sd39797;
	localparam logic [31:0]        TWO_PI_U   = 32'd411775;
	localparam logic [47:0]        STAMP_MAX  = 48'hFFFF_FFFF_FFFF;
	// 411775 shifted by 13 exceeds any angle magnitude, so 13 reduction steps suffice.
	localparam logic [4:0]         MOD_STEPS  = 5'd13;

	localparam logic [2:0] MODEL_CV   = 3'd0;
	localparam logic [2:0] MODEL_CA   = 3'd1;
	localparam logic [2:0] MODEL_CTRV = 3'd2;
	localparam logic [2:0] MODEL_CTRA = 3'd3;

	localparam logic [2:0] REG_MODEL   = 3'd0;
	localparam logic [2:0] REG_DT      = 3'd1;
	localparam logic [2:0] REG_HORIZON = 3'd2;
	localparam logic [2:0] REG_SLOW    = 3'd3;

	localparam logic [4:0] OP_NOP     = 5'd0;
	localparam logic [4:0] OP_LOAD    = 5'd1;
	localparam logic [4:0] OP_VMUL    = 5'd2;
	localparam logic [4:0] OP_VADD    = 5'd3;
	localparam logic [4:0] OP_VCOPY   = 5'd4;
	localparam logic [4:0] OP_VZ      = 5'd5;
	localparam logic [4:0] OP_UFROMV  = 5'd6;
	localparam logic [4:0] OP_AT_INIT = 5'd7;
	localparam logic [4:0] OP_AT_ITER = 5'd8;
	localparam logic [4:0] OP_AT_DONE = 5'd9;
	localparam logic [4:0] OP_WMUL    = 5'd10;
	localparam logic [4:0] OP_WSET    = 5'd11;
	localparam logic [4:0] OP_MOD     = 5'd12;
	localparam logic [4:0] OP_FOLD    = 5'd13;
	localparam logic [4:0] OP_SC_ITER = 5'd14;
	localparam logic [4:0] OP_SC_DONE = 5'd15;
	localparam logic [4:0] OP_RMUL    = 5'd16;
	localparam logic [4:0] OP_RACC    = 5'd17;
	localparam logic [4:0] OP_YAW     = 5'd18;
	localparam logic [4:0] OP_PMUL    = 5'd19;
	localparam logic [4:0] OP_PADD    = 5'd20;
	localparam logic [4:0] OP_STAMP   = 5'd21;

	typedef struct packed {
		logic [4:0] op;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic [2:0] model;
		logic [6:0] horizon;
		logic       ca_turn;
	} status_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] acc_z;
		logic signed [31:0] heading;
		logic signed [31:0] turn_rate;
		logic [47:0]        stamp;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] heading;
		logic [47:0]        stamp;
	} out_item_t;

	function automatic logic [15:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0:    return 16'd51472;
			5'd1:    return 16'd30386;
			5'd2:    return 16'd16055;
			5'd3:    return 16'd8150;
			5'd4:    return 16'd4091;
			5'd5:    return 16'd2047;
			5'd6:    return 16'd1024;
			5'd7:    return 16'd512;
			5'd8:    return 16'd256;
			5'd9:    return 16'd128;
			5'd10:   return 16'd64;
			5'd11:   return 16'd32;
			5'd12:   return 16'd16;
			5'd13:   return 16'd8;
			5'd14:   return 16'd4;
			5'd15:   return 16'd2;
			5'd16:   return 16'd1;
			default: return 16'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		if (v > 53'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -53'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

	// Round half up and drop sixteen fraction bits.
	function automatic logic signed [36:0] rnd16(input logic signed [51:0] v);
		logic signed [52:0] t;
		t = $signed({v[51], v}) + 53'sd32768;
		return t[52:16];
	endfunction

	function automatic logic signed [52:0] ext32(input logic signed [31:0] v);
		return $signed({{21{v[31]}}, v});
	endfunction

	function automatic logic signed [52:0] ext37(input logic signed [36:0] v);
		return $signed({{16{v[36]}}, v});
	endfunction

endpackage

FILE: sv/kmr_if.sv
// Channel interfaces for the rollout block: input state and predicted state.
// Depends on nothing; payload widths follow the package field types.
`timescale 1ns / 1ps
interface kmr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic signed [31:0] acc_x;
	logic signed [31:0] acc_y;
	logic signed [31:0] acc_z;
	logic signed [31:0] heading;
	logic signed [31:0] turn_rate;
	logic [47:0]        stamp;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		acc_x, acc_y, acc_z, heading, turn_rate, stamp, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		acc_x, acc_y, acc_z, heading, turn_rate, stamp, output ready);
endinterface

interface kmr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_pos_x;
	logic signed [31:0] out_pos_y;
	logic signed [31:0] out_pos_z;
	logic signed [31:0] out_vel_x;
	logic signed [31:0] out_vel_y;
	logic signed [31:0] out_vel_z;
	logic signed [31:0] out_heading;
	logic [47:0]        out_stamp;
	logic               last_step;

	modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
		out_vel_y, out_vel_z, out_heading, out_stamp, last_step, input ready);
	modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
		out_vel_y, out_vel_z, out_heading, out_stamp, last_step, output ready);
endinterface

FILE: sv/kmr_datapath.sv
// Datapath of the rollout: configuration registers, object state, one shared
// multiplier and a shared CORDIC unit. Depends on kmr_pkg.
`timescale 1ns / 1ps
module kmr_datapath import kmr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  in_item_t    in_item,
	output out_item_t   out_item
);

	logic [2:0]  model_q;
	logic [15:0] dt_q;
	logic [6:0]  horizon_q;
	logic [15:0] slow_q;

	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] a_q [3];
	logic signed [31:0] u_q [3];
	logic signed [31:0] yaw_q;
	logic signed [31:0] wr_q;
	logic [47:0]        stamp_q;
	logic signed [31:0] w_q;
	logic [31:0]        rem_q;
	logic               flip_q;
	logic signed [35:0] cx_q;
	logic signed [35:0] cy_q;
	logic signed [31:0] z_q;
	logic signed [19:0] c_q;
	logic signed [19:0] s_q;
	logic signed [51:0] prod_q;
	logic signed [51:0] acc_q;

	logic [1:0]         j;
	logic signed [31:0] mul_a;
	logic signed [19:0] mul_b;
	logic signed [19:0] dt_s;
	logic signed [51:0] prod_w;
	logic signed [36:0] rnd_p;
	logic signed [31:0] tab;
	logic signed [35:0] cx_sh;
	logic signed [35:0] cy_sh;
	logic [31:0]        kshift;
	logic signed [31:0] r0;
	logic signed [31:0] r1;
	logic signed [31:0] fold_r;
	logic               fold_flip;
	logic signed [35:0] vx36;
	logic signed [35:0] vy36;
	logic [32:0]        abs0;
	logic [32:0]        abs1;
	logic [48:0]        stamp_sum;
	logic signed [52:0] rot_sum;

	assign j      = cmd.idx[1:0];
	assign dt_s   = $signed({4'b0, dt_q});
	assign tab    = $signed({16'b0, atan_entry(cmd.idx)});
	assign cx_sh  = cx_q >>> cmd.idx;
	assign cy_sh  = cy_q >>> cmd.idx;
	assign kshift = TWO_PI_U << cmd.idx;
	assign vx36   = $signed({{4{v_q[0][31]}}, v_q[0]});
	assign vy36   = $signed({{4{v_q[1][31]}}, v_q[1]});
	assign stamp_sum = {1'b0, stamp_q} + {33'b0, dt_q};
	assign rnd_p  = rnd16(prod_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_VMUL: begin
				mul_a = a_q[j];
				mul_b = dt_s;
			end
			OP_WMUL: begin
				mul_a = wr_q;
				mul_b = dt_s;
			end
			OP_PMUL: begin
				mul_a = v_q[j];
				mul_b = dt_s;
			end
			OP_RMUL: begin
				case (j)
					2'd0: begin
						mul_a = u_q[0];
						mul_b = c_q;
					end
					2'd1: begin
						mul_a = u_q[1];
						mul_b = s_q;
					end
					2'd2: begin
						mul_a = u_q[1];
						mul_b = c_q;
					end
					default: begin
						mul_a = u_q[0];
						mul_b = s_q;
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_w = mul_a * mul_b;

	// Angle reduction into [-pi, pi], then folding into [-pi/2, pi/2].
	always_comb begin
		r0 = w_q[31] ? -$signed(rem_q) : $signed(rem_q);
		if (r0 > FX_PI) begin
			r1 = r0 - FX_TWO_PI;
		end else if (r0 < -FX_PI) begin
			r1 = r0 + FX_TWO_PI;
		end else begin
			r1 = r0;
		end
		fold_flip = 1'b0;
		fold_r    = r1;
		if (r1 > FX_HALF_PI) begin
			fold_r    = r1 - FX_PI;
			fold_flip = 1'b1;
		end else if (r1 < -FX_HALF_PI) begin
			fold_r    = r1 + FX_PI;
			fold_flip = 1'b1;
		end
	end

	always_comb begin
		abs0 = v_q[0][31] ? 33'(-ext32(v_q[0])) : {1'b0, v_q[0]};
		abs1 = v_q[1][31] ? 33'(-ext32(v_q[1])) : {1'b0, v_q[1]};
		rot_sum = (j == 2'd1) ? ($signed({acc_q[51], acc_q}) - $signed({prod_q[51], prod_q}))
			: ($signed({acc_q[51], acc_q}) + $signed({prod_q[51], prod_q}));
	end

	assign status.model   = model_q;
	assign status.horizon = horizon_q;
	assign status.ca_turn = !(abs0 <= {17'b0, slow_q} && abs1 <= {17'b0, slow_q})
		&& (v_q[0] != 32'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q   <= MODEL_CV;
			dt_q      <= 16'd6554;
			horizon_q <= 7'd30;
			slow_q    <= 16'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODEL:   model_q   <= cfg_data[2:0];
				REG_DT:      dt_q      <= cfg_data;
				REG_HORIZON: horizon_q <= cfg_data[6:0];
				REG_SLOW:    slow_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_w;
		case (cmd.op)
			OP_LOAD: begin
				p_q[0]  <= in_item.pos_x;
				p_q[1]  <= in_item.pos_y;
				p_q[2]  <= in_item.pos_z;
				v_q[0]  <= in_item.vel_x;
				v_q[1]  <= in_item.vel_y;
				v_q[2]  <= in_item.vel_z;
				a_q[0]  <= in_item.acc_x;
				a_q[1]  <= in_item.acc_y;
				a_q[2]  <= in_item.acc_z;
				yaw_q   <= in_item.heading;
				wr_q    <= in_item.turn_rate;
				stamp_q <= in_item.stamp;
			end
			OP_VADD:   u_q[j] <= sat32(ext32(v_q[j]) + ext37(rnd16(prod_q)));
			OP_VCOPY: begin
				v_q[0] <= u_q[0];
				v_q[1] <= u_q[1];
				v_q[2] <= u_q[2];
			end
			OP_VZ:     v_q[2] <= u_q[2];
			OP_UFROMV: begin
				u_q[0] <= v_q[0];
				u_q[1] <= v_q[1];
			end
			OP_AT_INIT: begin
				if (v_q[0][31]) begin
					if (!v_q[1][31]) begin
						cx_q <= vy36;
						cy_q <= -vx36;
						z_q  <= FX_HALF_PI;
					end else begin
						cx_q <= -vy36;
						cy_q <= vx36;
						z_q  <= -FX_HALF_PI;
					end
				end else begin
					cx_q <= vx36;
					cy_q <= vy36;
					z_q  <= 32'sd0;
				end
			end
			OP_AT_ITER: begin
				if (cy_q > 36'sd0) begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					z_q  <= z_q + tab;
				end else begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					z_q  <= z_q - tab;
				end
			end
			OP_AT_DONE: yaw_q <= z_q;
			OP_WSET: begin
				w_q   <= rnd_p[31:0];
				rem_q <= rnd_p[31] ? 32'(-rnd_p) : rnd_p[31:0];
			end
			OP_MOD: begin
				if (rem_q >= kshift) begin
					rem_q <= rem_q - kshift;
				end
			end
			OP_FOLD: begin
				z_q    <= fold_r;
				flip_q <= fold_flip;
				cx_q   <= FX_GAIN;
				cy_q   <= 36'sd0;
			end
			OP_SC_ITER: begin
				if (!z_q[31]) begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					z_q  <= z_q - tab;
				end else begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					z_q  <= z_q + tab;
				end
			end
			OP_SC_DONE: begin
				c_q <= flip_q ? 20'(-cx_q) : cx_q[19:0];
				s_q <= flip_q ? 20'(-cy_q) : cy_q[19:0];
			end
			OP_RACC: begin
				case (j)
					2'd0, 2'd2: acc_q <= prod_q;
					2'd1:       v_q[0] <= sat32(ext37(rnd16(rot_sum[51:0])));
					default:    v_q[1] <= sat32(ext37(rnd16(rot_sum[51:0])));
				endcase
			end
			OP_YAW:    yaw_q <= sat32(ext32(yaw_q) + ext32(w_q));
			OP_PADD:   p_q[j] <= sat32(ext32(p_q[j]) + ext37(rnd16(prod_q)));
			OP_STAMP:  stamp_q <= stamp_sum[48] ? STAMP_MAX : stamp_sum[47:0];
			default:   ;
		endcase
	end

	assign out_item.pos_x   = p_q[0];
	assign out_item.pos_y   = p_q[1];
	assign out_item.pos_z   = p_q[2];
	assign out_item.vel_x   = v_q[0];
	assign out_item.vel_y   = v_q[1];
	assign out_item.vel_z   = v_q[2];
	assign out_item.heading = yaw_q;
	assign out_item.stamp   = stamp_q;

endmodule

FILE: sv/kmr_ctrl.sv
// Controller of the rollout: sequences the datapath through each prediction
// step and runs both channel handshakes. Depends on kmr_pkg.
`timescale 1ns / 1ps
module kmr_ctrl import kmr_pkg::*; #(
	parameter int MAX_HORIZON   = 64,
	parameter int CORDIC_STAGES = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output logic    last_step,
	output cmd_t    cmd,
	input  status_t status
);

	localparam int CW = $clog2(MAX_HORIZON + 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_EMIT   = 5'd1;
	localparam logic [4:0] S_VMUL   = 5'd2;
	localparam logic [4:0] S_VADD   = 5'd3;
	localparam logic [4:0] S_VFIN   = 5'd4;
	localparam logic [4:0] S_CATEST = 5'd5;
	localparam logic [4:0] S_ATAN   = 5'd6;
	localparam logic [4:0] S_ATDONE = 5'd7;
	localparam logic [4:0] S_UCOPY  = 5'd8;
	localparam logic [4:0] S_WMUL   = 5'd9;
	localparam logic [4:0] S_WSET   = 5'd10;
	localparam logic [4:0] S_MOD    = 5'd11;
	localparam logic [4:0] S_FOLD   = 5'd12;
	localparam logic [4:0] S_SC     = 5'd13;
	localparam logic [4:0] S_SCDONE = 5'd14;
	localparam logic [4:0] S_RMUL   = 5'd15;
	localparam logic [4:0] S_RACC   = 5'd16;
	localparam logic [4:0] S_YAW    = 5'd17;
	localparam logic [4:0] S_PMUL   = 5'd18;
	localparam logic [4:0] S_PADD   = 5'd19;
	localparam logic [4:0] S_STAMP  = 5'd20;

	localparam logic [4:0] LAST_ITER = 5'(CORDIC_STAGES - 1);

	logic [4:0]    state_q;
	logic [4:0]    idx_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] n_clamped;

	always_comb begin
		if (status.horizon == 7'd0) begin
			n_clamped = CW'(1);
		end else if (int'(status.horizon) > MAX_HORIZON) begin
			n_clamped = CW'(MAX_HORIZON);
		end else begin
			n_clamped = CW'(status.horizon);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign last_step = (cnt_q == n_q - CW'(1));

	always_comb begin
		cmd.idx = idx_q;
		case (state_q)
			S_IDLE:   cmd.op = in_valid ? OP_LOAD : OP_NOP;
			S_VMUL:   cmd.op = OP_VMUL;
			S_VADD:   cmd.op = OP_VADD;
			S_VFIN:   cmd.op = (status.model == MODEL_CA) ? OP_VCOPY : OP_VZ;
			S_CATEST: cmd.op = OP_AT_INIT;
			S_ATAN:   cmd.op = OP_AT_ITER;
			S_ATDONE: cmd.op = OP_AT_DONE;
			S_UCOPY:  cmd.op = OP_UFROMV;
			S_WMUL:   cmd.op = OP_WMUL;
			S_WSET:   cmd.op = OP_WSET;
			S_MOD:    cmd.op = OP_MOD;
			S_FOLD:   cmd.op = OP_FOLD;
			S_SC:     cmd.op = OP_SC_ITER;
			S_SCDONE: cmd.op = OP_SC_DONE;
			S_RMUL:   cmd.op = OP_RMUL;
			S_RACC:   cmd.op = OP_RACC;
			S_YAW:    cmd.op = OP_YAW;
			S_PMUL:   cmd.op = OP_PMUL;
			S_PADD:   cmd.op = OP_PADD;
			S_STAMP:  cmd.op = OP_STAMP;
			default:  cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			n_q     <= CW'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EMIT;
						cnt_q   <= '0;
						n_q     <= n_clamped;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						idx_q <= '0;
						if (last_step) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + CW'(1);
							case (status.model)
								MODEL_CV:               state_q <= S_PMUL;
								MODEL_CA, MODEL_CTRA:   state_q <= S_VMUL;
								MODEL_CTRV:             state_q <= S_UCOPY;
								default:                state_q <= S_STAMP;
							endcase
						end
					end
				end
				S_VMUL: state_q <= S_VADD;
				S_VADD: begin
					if (idx_q == 5'd2) begin
						state_q <= S_VFIN;
						idx_q   <= '0;
					end else begin
						state_q <= S_VMUL;
						idx_q   <= idx_q + 5'd1;
					end
				end
				S_VFIN: state_q <= (status.model == MODEL_CA) ? S_CATEST : S_WMUL;
				S_CATEST: begin
					idx_q   <= '0;
					state_q <= status.ca_turn ? S_ATAN : S_PMUL;
				end
				S_ATAN: begin
					if (idx_q == LAST_ITER) begin
						state_q <= S_ATDONE;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				S_ATDONE: state_q <= S_PMUL;
				S_UCOPY:  state_q <= S_WMUL;
				S_WMUL:   state_q <= S_WSET;
				S_WSET: begin
					state_q <= S_MOD;
					idx_q   <= MOD_STEPS - 5'd1;
				end
				S_MOD: begin
					if (idx_q == 5'd0) begin
						state_q <= S_FOLD;
					end else begin
						idx_q <= idx_q - 5'd1;
					end
				end
				S_FOLD: begin
					state_q <= S_SC;
					idx_q   <= '0;
				end
				S_SC: begin
					if (idx_q == LAST_ITER) begin
						state_q <= S_SCDONE;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 5'd1;
					end
				end
				S_SCDONE: state_q <= S_RMUL;
				S_RMUL:   state_q <= S_RACC;
				S_RACC: begin
					if (idx_q == 5'd3) begin
						state_q <= S_YAW;
						idx_q   <= '0;
					end else begin
						state_q <= S_RMUL;
						idx_q   <= idx_q + 5'd1;
					end
				end
				S_YAW: begin
					state_q <= S_PMUL;
					idx_q   <= '0;
				end
				S_PMUL: state_q <= S_PADD;
				S_PADD: begin
					if (idx_q == 5'd2) begin
						state_q <= S_STAMP;
						idx_q   <= '0;
					end else begin
						state_q <= S_PMUL;
						idx_q   <= idx_q + 5'd1;
					end
				end
				S_STAMP: state_q <= S_EMIT;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/kinematic_motion_rollout.sv
// Usage notes for the kinematic motion rollout.
// One transaction on in_ch carries an object's current state. The block then
// emits horizon_steps states on out_ch (at least one, at most MAX_HORIZON):
// the current state first, then one predicted state per step_time, with
// last_step high on the final one. Configuration must be written through
// cfg_we/cfg_index/cfg_data while the block is idle; this is not enforced.
// The first state is offered in the cycle after the input transaction.
// Each further state is offered after the step computation, which differs for
// an invalid model, CV, CA with heading held, CA with the heading recomputed,
// CTRV and CTRA. The computation is paced by the single shared multiplier, the
// 13-step angle reduction and the one-iteration-per-cycle CORDIC. A new object
// is taken only after the last state has been delivered.
// If the receiver stalls, the offered state holds and the computation waits.
// Reset returns the block to idle with the default configuration.
// Depends on kmr_pkg, kmr_if, kmr_ctrl, kmr_datapath and the assertion header.
`timescale 1ns / 1ps
`include "kinematic_motion_rollout_assert.svh"
module kinematic_motion_rollout import kmr_pkg::*; #(
	parameter int MAX_HORIZON   = 64,
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	kmr_in_if.sink      in_ch,
	kmr_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t      cmd;
	status_t   status;
	in_item_t  in_item;
	out_item_t out_item;
	logic      last_step;

	assign in_item.pos_x     = in_ch.pos_x;
	assign in_item.pos_y     = in_ch.pos_y;
	assign in_item.pos_z     = in_ch.pos_z;
	assign in_item.vel_x     = in_ch.vel_x;
	assign in_item.vel_y     = in_ch.vel_y;
	assign in_item.vel_z     = in_ch.vel_z;
	assign in_item.acc_x     = in_ch.acc_x;
	assign in_item.acc_y     = in_ch.acc_y;
	assign in_item.acc_z     = in_ch.acc_z;
	assign in_item.heading   = in_ch.heading;
	assign in_item.turn_rate = in_ch.turn_rate;
	assign in_item.stamp     = in_ch.stamp;

	kmr_ctrl #(
		.MAX_HORIZON   (MAX_HORIZON),
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.last_step (last_step),
		.cmd       (cmd),
		.status    (status)
	);

	kmr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_item  (out_item)
	);

	assign out_ch.out_pos_x   = out_item.pos_x;
	assign out_ch.out_pos_y   = out_item.pos_y;
	assign out_ch.out_pos_z   = out_item.pos_z;
	assign out_ch.out_vel_x   = out_item.vel_x;
	assign out_ch.out_vel_y   = out_item.vel_y;
	assign out_ch.out_vel_z   = out_item.vel_z;
	assign out_ch.out_heading = out_item.heading;
	assign out_ch.out_stamp   = out_item.stamp;
	assign out_ch.last_step   = last_step;

	// One object at a time: no input is taken while a state is on offer.
	`KMR_ASSERT_IMP(a_no_overlap, in_ch.ready, !out_ch.valid)
	// The current state is offered straight after the input transaction.
	`KMR_ASSERT_NXT(a_first_out, in_ch.valid && in_ch.ready, out_ch.valid && cmd.op == OP_NOP)
	// Delivering the final state returns the block to idle.
	`KMR_ASSERT_NXT(a_end_idle, out_ch.valid && out_ch.ready && last_step, in_ch.ready)
	// The datapath only loads while an input transaction completes.
	`KMR_ASSERT_IMP(a_load_on_accept, cmd.op == OP_LOAD, in_ch.valid && in_ch.ready)

endmodule
